// ===== design/mctc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the MM:SS cooking timer controller.
// Holds the field widths, command and reply codes, and the request, result and state types.
package mctc_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned REPLY_W  = 2;
    localparam int unsigned ALARM_W  = 4;
    localparam int unsigned N_DIGITS = 4;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
    localparam logic [DIGIT_W-1:0] SEC_TENS_MAX = 4'd5;
    localparam logic [ALARM_W-1:0] ALARM_TICKS_RST = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_DIGIT = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef enum logic [REPLY_W-1:0] {
        REPLY_NONE    = 2'd0,
        REPLY_READY   = 2'd1,
        REPLY_CLEARED = 2'd2
    } t_reply;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   digit_position;
        logic [DIGIT_W-1:0] digit_value;
        logic               door_closed;
    } t_req;

    typedef struct packed {
        logic [REPLY_W-1:0] reply;
        logic [DIGIT_W-1:0] sec_units;
        logic [DIGIT_W-1:0] sec_tens;
        logic [DIGIT_W-1:0] min_units;
        logic [DIGIT_W-1:0] min_tens;
        logic               running;
        logic               buzzer;
    } t_rsp;

    typedef struct packed {
        logic [N_DIGITS-1:0][DIGIT_W-1:0] digits;
        logic                             running;
        logic                             alarm_active;
        logic [ALARM_W-1:0]               alarm_count;
    } t_state;

endpackage

// ===== design/mctc_ifs.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces for the cooking timer controller.
// Depends on mctc_pkg for field widths.
interface mctc_req_if;
    logic                            valid;
    logic                            ready;
    logic [mctc_pkg::CMD_W-1:0]      cmd;
    logic [mctc_pkg::POS_W-1:0]      digit_position;
    logic [mctc_pkg::DIGIT_W-1:0]    digit_value;
    logic                            door_closed;

    modport source (output valid, cmd, digit_position, digit_value, door_closed, input ready);
    modport sink   (input valid, cmd, digit_position, digit_value, door_closed, output ready);
endinterface

interface mctc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [mctc_pkg::REPLY_W-1:0]    reply;
    logic [mctc_pkg::DIGIT_W-1:0]    sec_units;
    logic [mctc_pkg::DIGIT_W-1:0]    sec_tens;
    logic [mctc_pkg::DIGIT_W-1:0]    min_units;
    logic [mctc_pkg::DIGIT_W-1:0]    min_tens;
    logic                            running;
    logic                            buzzer;

    modport source (output valid, reply, sec_units, sec_tens, min_units, min_tens, running,
                    buzzer, input ready);
    modport sink   (input valid, reply, sec_units, sec_tens, min_units, min_tens, running,
                    buzzer, output ready);
endinterface

// ===== design/mctc_step.sv =====
`timescale 1ns / 1ps
// Next-state and result logic for one timer request: digit entry, start, stop, tick.
// Depends on mctc_pkg.
module mctc_step (
    input  mctc_pkg::t_state               i_state,
    input  mctc_pkg::t_req                 i_req,
    input  logic [mctc_pkg::ALARM_W-1:0]   i_alarm_ticks,
    output mctc_pkg::t_state               o_state,
    output mctc_pkg::t_rsp                 o_rsp
);

    logic [mctc_pkg::DIGIT_W-1:0] digit_sat;
    logic                         time_zero;
    logic [mctc_pkg::N_DIGITS-1:0][mctc_pkg::DIGIT_W-1:0] dec_digits;
    logic [mctc_pkg::ALARM_W-1:0] alarm_dec;
    mctc_pkg::t_state             nxt;
    mctc_pkg::t_reply             reply;

    assign digit_sat = (i_req.digit_value > mctc_pkg::DIGIT_MAX) ? mctc_pkg::DIGIT_MAX
                                                                  : i_req.digit_value;
    assign time_zero = (i_state.digits == '0);
    assign alarm_dec = (i_state.alarm_count != '0) ? i_state.alarm_count - 1'b1
                                                   : i_state.alarm_count;

    // BCD countdown with seconds tens wrapping to five
    always_comb begin
        dec_digits = i_state.digits;
        if (i_state.digits[0] != '0) begin
            dec_digits[0] = i_state.digits[0] - 1'b1;
        end else begin
            dec_digits[0] = mctc_pkg::DIGIT_MAX;
            if (i_state.digits[1] != '0) begin
                dec_digits[1] = i_state.digits[1] - 1'b1;
            end else begin
                dec_digits[1] = mctc_pkg::SEC_TENS_MAX;
                if (i_state.digits[2] != '0) begin
                    dec_digits[2] = i_state.digits[2] - 1'b1;
                end else begin
                    dec_digits[2] = mctc_pkg::DIGIT_MAX;
                    if (i_state.digits[3] != '0) begin
                        dec_digits[3] = i_state.digits[3] - 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        nxt   = i_state;
        reply = mctc_pkg::REPLY_NONE;
        case (mctc_pkg::t_cmd'(i_req.cmd))
            mctc_pkg::CMD_DIGIT: begin
                if (i_req.digit_position inside {[3'd1:3'd4]}) begin
                    if (i_req.digit_position >= 3'd4) begin
                        nxt.digits[3] = i_state.digits[2];
                    end
                    if (i_req.digit_position >= 3'd3) begin
                        nxt.digits[2] = i_state.digits[1];
                    end
                    if (i_req.digit_position >= 3'd2) begin
                        nxt.digits[1] = i_state.digits[0];
                    end
                    nxt.digits[0] = digit_sat;
                end
            end
            mctc_pkg::CMD_START: begin
                nxt.alarm_active = 1'b0;
                nxt.alarm_count  = '0;
                if (i_req.door_closed && !time_zero) begin
                    nxt.running = 1'b1;
                end else begin
                    reply = mctc_pkg::REPLY_READY;
                end
            end
            mctc_pkg::CMD_STOP: begin
                if (i_state.running) begin
                    nxt.running = 1'b0;
                    reply       = mctc_pkg::REPLY_READY;
                end else begin
                    nxt.digits = '0;
                    reply      = mctc_pkg::REPLY_CLEARED;
                end
            end
            mctc_pkg::CMD_TICK: begin
                if (i_state.running) begin
                    if (time_zero) begin
                        nxt.running      = 1'b0;
                        nxt.digits       = '0;
                        nxt.alarm_active = 1'b1;
                        nxt.alarm_count  = (i_alarm_ticks == '0) ? 4'd1 : i_alarm_ticks;
                    end else begin
                        nxt.digits = dec_digits;
                    end
                end else if (i_state.alarm_active) begin
                    nxt.alarm_count = alarm_dec;
                    if (alarm_dec == '0) begin
                        nxt.alarm_active = 1'b0;
                        reply            = mctc_pkg::REPLY_READY;
                    end
                end
            end
            default: begin
                nxt = i_state;
            end
        endcase
    end

    assign o_state         = nxt;
    assign o_rsp.reply     = reply;
    assign o_rsp.sec_units = nxt.digits[0];
    assign o_rsp.sec_tens  = nxt.digits[1];
    assign o_rsp.min_units = nxt.digits[2];
    assign o_rsp.min_tens  = nxt.digits[3];
    assign o_rsp.running   = nxt.running;
    assign o_rsp.buzzer    = nxt.alarm_active;

endmodule

// ===== design/mmss_cook_timer_controller_core.sv =====
`timescale 1ns / 1ps
// Top level of the MM:SS cooking timer controller: state, alarm length register, result stage.
// Depends on mctc_pkg, mctc_ifs and mctc_step.

// Every request (digit entry, start, stop, one-second tick) yields exactly one result carrying
// the reply code and the display digits, running and buzzer after the request. A request is
// taken in every cycle while the skid stage is empty, and its result is registered.
// The result register is backed by a one-entry skid stage, so a stalled result channel holds
// off requests only once both are full. The alarm length register resets to two and should be
// written only while no results are outstanding. The running output drives motor and light.
module mmss_cook_timer_controller_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mctc_pkg::ALARM_W-1:0]  i_cfg_wdata,
    mctc_req_if.sink                      i_req,
    mctc_rsp_if.source                    o_rsp
);

    mctc_pkg::t_state             r_state;
    mctc_pkg::t_state             n_state;
    logic [mctc_pkg::ALARM_W-1:0] r_alarm_ticks;
    logic                         r_out_valid;
    logic                         n_out_valid;
    mctc_pkg::t_rsp               r_out;
    mctc_pkg::t_rsp               n_out;
    logic                         r_skid_valid;
    logic                         n_skid_valid;
    mctc_pkg::t_rsp               r_skid;
    mctc_pkg::t_rsp               n_skid;

    mctc_pkg::t_req               req;
    mctc_pkg::t_state             step_state;
    mctc_pkg::t_rsp               step_rsp;
    logic                         accept;

    assign req.cmd            = i_req.cmd;
    assign req.digit_position = i_req.digit_position;
    assign req.digit_value    = i_req.digit_value;
    assign req.door_closed    = i_req.door_closed;

    mctc_step u_step (
        .i_state       (r_state),
        .i_req         (req),
        .i_alarm_ticks (r_alarm_ticks),
        .o_state       (step_state),
        .o_rsp         (step_rsp)
    );

    assign i_req.ready = !r_skid_valid;
    assign accept      = i_req.valid && !r_skid_valid;

    always_comb begin
        n_state      = accept ? step_state : r_state;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || o_rsp.ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                n_out       = step_rsp;
            end
        end else if (accept) begin
            // hold the stalled result, park the new one
            n_skid_valid = 1'b1;
            n_skid       = step_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_alarm_ticks <= mctc_pkg::ALARM_TICKS_RST;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (i_cfg_we) begin
                r_alarm_ticks <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.reply     = r_out.reply;
    assign o_rsp.sec_units = r_out.sec_units;
    assign o_rsp.sec_tens  = r_out.sec_tens;
    assign o_rsp.min_units = r_out.min_units;
    assign o_rsp.min_tens  = r_out.min_tens;
    assign o_rsp.running   = r_out.running;
    assign o_rsp.buzzer    = r_out.buzzer;

endmodule
